FILE: sv/minhash_bucket_greedy_dedup_unit_macros.svh
// Assertion helpers shared by the block's modules.
// Each one assumes signals named clk and arst_n in the using module.
`ifndef MINHASH_BUCKET_GREEDY_DEDUP_UNIT_MACROS_SVH
`define MINHASH_BUCKET_GREEDY_DEDUP_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MHBD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MHBD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/mhbd_pkg.sv
package mhbd_pkg;

	// Register file layout
	localparam int CFG_W = 9;
	localparam int CFG_IDX_W = 8;
	localparam logic [CFG_IDX_W-1:0] CFG_SIG_WORDS = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_MATCHES = 8'd1;
	localparam logic [CFG_W-1:0] SIG_WORDS_RST = 9'd256;
	localparam logic [CFG_W-1:0] MIN_MATCHES_RST = 9'd205;

	// Field widths
	localparam int ID_W = 32;
	localparam int WORD_W = 64;

	// Request codes
	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_RUN = 1'b1;

	// Result codes
	localparam logic KIND_PAIR = 1'b0;
	localparam logic KIND_END = 1'b1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PIVOT,
		S_CAND,
		S_ISSUE,
		S_DRAIN,
		S_END
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic load;
		logic idx_clr;
		logic idx_inc;
		logic set_pivot;
		logic start_cmp;
		logic issue;
		logic emit_pair;
		logic emit_end;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic alive_bit;
		logic idx_end;
		logic words_done;
		logic pipe_busy;
		logic is_dup;
		logic out_free;
	} status_t;

endpackage

FILE: sv/minhash_bucket_greedy_dedup_unit.sv
// Load requests: one signature word per cycle, no result.
// Run request: input stalls until the run has compared all members and sent its end
//   result; the signature memory walks one word position per cycle on two read ports.
// Results leave through an output register; a new request is taken while one waits.
// Reset (arst_n low, asynchronous) empties the bucket and loads register defaults.
module minhash_bucket_greedy_dedup_unit
	import mhbd_pkg::*;
#(
	parameter int MAX_MEMBERS = 32,
	parameter int MAX_WORDS = 256
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [95:0]          s_axis_tdata,  // doc_id[31:0], sig_word[95:32]
	input  logic                 s_axis_tuser,  // func[0]
	input  logic                 s_axis_tlast,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [63:0]          m_axis_tdata,  // leader_id[31:0], dup_id[63:32]
	output logic                 m_axis_tuser,  // kind[0]
	output logic                 m_axis_tlast,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	cmd_t cmd;
	status_t st;
	logic [ID_W-1:0] leader_id, dup_id;

	assign cfg_ready = 1'b1;

	mhbd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_func  (s_axis_tuser),
		.in_ready (s_axis_tready),
		.st       (st),
		.cmd      (cmd)
	);

	mhbd_dpath #(
		.MAX_MEMBERS (MAX_MEMBERS),
		.MAX_WORDS   (MAX_WORDS)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.st            (st),
		.in_doc_id     (s_axis_tdata[31:0]),
		.in_sig_word   (s_axis_tdata[95:32]),
		.in_end        (s_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.m_tready      (m_axis_tready),
		.out_valid     (m_axis_tvalid),
		.out_kind      (m_axis_tuser),
		.out_leader_id (leader_id),
		.out_dup_id    (dup_id),
		.out_last      (m_axis_tlast)
	);

	assign m_axis_tdata = {dup_id, leader_id};

endmodule

FILE: sv/mhbd_ctrl.sv
`include "minhash_bucket_greedy_dedup_unit_macros.svh"

module mhbd_ctrl
	import mhbd_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  logic    in_func,
	output logic    in_ready,
	input  status_t st,
	output cmd_t    cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid && in_func == FUNC_RUN) state_d = S_PIVOT;
			end
			S_PIVOT: begin
				if (st.idx_end) state_d = S_END;
				else if (st.alive_bit) state_d = S_CAND;
			end
			S_CAND: begin
				if (st.idx_end) state_d = S_PIVOT;
				else if (st.alive_bit) state_d = S_ISSUE;
			end
			S_ISSUE: begin
				if (st.words_done) state_d = S_DRAIN;
			end
			S_DRAIN: begin
				if (!st.pipe_busy && (!st.is_dup || st.out_free)) state_d = S_CAND;
			end
			S_END: begin
				if (st.out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Commands
	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid && in_func == FUNC_LOAD;
				cmd.idx_clr = in_valid && in_func == FUNC_RUN;
			end
			S_PIVOT: begin
				if (!st.idx_end) begin
					cmd.set_pivot = st.alive_bit;
					cmd.idx_inc = 1'b1;
				end
			end
			S_CAND: begin
				if (st.idx_end) cmd.idx_clr = 1'b1;
				else if (st.alive_bit) cmd.start_cmp = 1'b1;
				else cmd.idx_inc = 1'b1;
			end
			S_ISSUE: begin
				cmd.issue = !st.words_done;
			end
			S_DRAIN: begin
				if (!st.pipe_busy) begin
					if (!st.is_dup) begin
						cmd.idx_inc = 1'b1;
					end else if (st.out_free) begin
						cmd.emit_pair = 1'b1;
						cmd.idx_inc = 1'b1;
					end
				end
			end
			S_END: begin
				cmd.emit_end = st.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	`MHBD_ASSERT_NOW(a_cand_live, (state_q == S_ISSUE || state_q == S_DRAIN), (st.alive_bit && !st.idx_end), "candidate left live set during compare")
	`MHBD_ASSERT_NOW(a_issue_bound, cmd.issue, (!st.words_done && state_q == S_ISSUE), "word read past signature end")

endmodule

FILE: sv/mhbd_dpath.sv
`include "minhash_bucket_greedy_dedup_unit_macros.svh"

module mhbd_dpath
	import mhbd_pkg::*;
#(
	parameter int MAX_MEMBERS = 32,
	parameter int MAX_WORDS = 256
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cmd_t                 cmd,
	output status_t              st,
	input  logic [ID_W-1:0]      in_doc_id,
	input  logic [WORD_W-1:0]    in_sig_word,
	input  logic                 in_end,
	input  logic                 cfg_valid,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 m_tready,
	output logic                 out_valid,
	output logic                 out_kind,
	output logic [ID_W-1:0]      out_leader_id,
	output logic [ID_W-1:0]      out_dup_id,
	output logic                 out_last
);

	localparam int DEPTH = MAX_MEMBERS * MAX_WORDS;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int MIW = $clog2(MAX_MEMBERS);
	localparam int MCW = $clog2(MAX_MEMBERS + 1);
	localparam int WCW = $clog2(MAX_WORDS + 1);
	localparam int LW = (WCW > CFG_W) ? WCW : CFG_W;
	localparam logic [ADDR_W-1:0] ROW_A = ADDR_W'(MAX_WORDS);
	localparam logic [MCW-1:0] MEMBERS_C = MCW'(MAX_MEMBERS);
	localparam logic [WCW-1:0] WORDS_C = WCW'(MAX_WORDS);

	logic [CFG_W-1:0] sig_words_q, min_matches_q;
	logic [MAX_MEMBERS-1:0] alive_q, alive_d;
	logic [MCW-1:0] member_cnt_q;
	logic [WCW-1:0] wi_q;
	logic [MCW-1:0] idx_q;
	logic [MIW-1:0] piv_q;
	logic [WCW-1:0] w_q;
	logic [WCW-1:0] match_q;
	logic valid_s1;
	logic [WORD_W-1:0] rd_a_s1, rd_b_s1;
	logic [ID_W-1:0] piv_id_q, cand_id_q;
	logic out_valid_q;

	logic [WORD_W-1:0] sig_mem [DEPTH];
	logic [ID_W-1:0] id_mem [MAX_MEMBERS];

	logic has_room, wi_room;
	logic [MIW-1:0] cnt_i, idx_i;
	logic [ADDR_W-1:0] wr_addr, addr_a, addr_b;
	logic [LW-1:0] words_lim;

	assign has_room = member_cnt_q < MEMBERS_C;
	assign wi_room = wi_q < WORDS_C;
	assign cnt_i = member_cnt_q[MIW-1:0];
	assign idx_i = idx_q[MIW-1:0];
	assign wr_addr = ADDR_W'(cnt_i) * ROW_A + ADDR_W'(wi_q);
	assign addr_a = ADDR_W'(piv_q) * ROW_A + ADDR_W'(w_q);
	assign addr_b = ADDR_W'(idx_i) * ROW_A + ADDR_W'(w_q);
	assign words_lim = (LW'(sig_words_q) > LW'(MAX_WORDS)) ? LW'(MAX_WORDS) : LW'(sig_words_q);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sig_words_q <= SIG_WORDS_RST;
			min_matches_q <= MIN_MATCHES_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_SIG_WORDS: sig_words_q <= cfg_data;
				CFG_MIN_MATCHES: min_matches_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Signature memory: one write port for loads, two registered read ports
	always_ff @(posedge clk) begin
		if (cmd.load && has_room && wi_room) sig_mem[wr_addr] <= in_sig_word;
		rd_a_s1 <= sig_mem[addr_a];
		rd_b_s1 <= sig_mem[addr_b];
	end

	// Member ids; the id given with the last word wins
	always_ff @(posedge clk) begin
		if (cmd.load && has_room) id_mem[cnt_i] <= in_doc_id;
		if (cmd.set_pivot) piv_id_q <= id_mem[idx_i];
		if (cmd.start_cmp) cand_id_q <= id_mem[idx_i];
	end

	// Live set update
	always_comb begin
		alive_d = alive_q;
		if (cmd.load && in_end && has_room) alive_d[cnt_i] = 1'b1;
		if (cmd.set_pivot || cmd.emit_pair) alive_d[idx_i] = 1'b0;
		if (cmd.emit_end) alive_d = '0;
	end

	// Bucket fill state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alive_q <= '0;
			member_cnt_q <= '0;
			wi_q <= '0;
		end else begin
			alive_q <= alive_d;
			if (cmd.emit_end) begin
				member_cnt_q <= '0;
				wi_q <= '0;
			end else if (cmd.load) begin
				if (in_end) begin
					if (has_room) member_cnt_q <= member_cnt_q + 1'b1;
					wi_q <= '0;
				end else if (wi_room) begin
					wi_q <= wi_q + 1'b1;
				end
			end
		end
	end

	// Scan index, pivot and word walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			piv_q <= '0;
			w_q <= '0;
			match_q <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (cmd.idx_clr) idx_q <= '0;
			else if (cmd.idx_inc) idx_q <= idx_q + 1'b1;
			if (cmd.set_pivot) piv_q <= idx_i;
			if (cmd.start_cmp) w_q <= '0;
			else if (cmd.issue) w_q <= w_q + 1'b1;
			valid_s1 <= cmd.issue;
			if (cmd.start_cmp) match_q <= '0;
			else if (valid_s1 && rd_a_s1 == rd_b_s1) match_q <= match_q + 1'b1;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_pair || cmd.emit_end) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_pair) begin
			out_kind <= KIND_PAIR;
			out_leader_id <= piv_id_q;
			out_dup_id <= cand_id_q;
			out_last <= 1'b0;
		end else if (cmd.emit_end) begin
			out_kind <= KIND_END;
			out_leader_id <= '0;
			out_dup_id <= '0;
			out_last <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;

	// Status back to the controller
	always_comb begin
		st.idx_end = idx_q == MEMBERS_C;
		st.alive_bit = !st.idx_end && alive_q[idx_i];
		st.words_done = LW'(w_q) >= words_lim;
		st.pipe_busy = valid_s1;
		st.is_dup = LW'(match_q) >= LW'(min_matches_q);
		st.out_free = !out_valid_q || m_tready;
	end

	`MHBD_ASSERT_NOW(a_no_overwrite, (cmd.emit_pair || cmd.emit_end), (!out_valid_q || m_tready), "pending result overwritten")
	`MHBD_ASSERT_NEXT(a_end_clears, cmd.emit_end, (alive_q == '0 && member_cnt_q == '0 && wi_q == '0), "bucket not emptied after run")

endmodule
